>>> sv/assert_macros.svh
// Assertion helpers; the enclosing module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

>>> sv/qcct_pkg.sv
package qcct_pkg;

  localparam int DEF_COUNT_BITS = 16;
  localparam int OUT_W          = 16;
  localparam int REQ_W          = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_RESERVE   = 3'd0,
    REQ_CANCEL    = 3'd1,
    REQ_COMMIT_RM = 3'd2,
    REQ_ATTEMPT_RM = 3'd3,
    REQ_RESIZE    = 3'd4
  } req_kind_t;

endpackage

>>> sv/qcct_update.sv
module qcct_update import qcct_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic [REQ_W-1:0]      req_type,
  input  logic [OUT_W-1:0]      new_capacity,
  input  logic [COUNT_BITS-1:0] free_cur,
  input  logic [COUNT_BITS-1:0] used_cur,
  input  logic [COUNT_BITS-1:0] debt_cur,
  input  logic [COUNT_BITS-1:0] max_cur,
  output logic [COUNT_BITS-1:0] free_nxt,
  output logic [COUNT_BITS-1:0] used_nxt,
  output logic [COUNT_BITS-1:0] debt_nxt,
  output logic [COUNT_BITS-1:0] max_nxt,
  output logic                  ok_nxt
);

  localparam int EW = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] a);
    return (&a) ? a : a + 1'b1;
  endfunction

  req_kind_t             kind;
  logic [EW-1:0]         cap_ext;
  logic [COUNT_BITS-1:0] cap_sat;
  logic [COUNT_BITS-1:0] diff_up;
  logic [COUNT_BITS-1:0] diff_dn;
  logic [COUNT_BITS-1:0] paid;
  logic [COUNT_BITS-1:0] taken;

  assign kind    = req_kind_t'(req_type);
  assign cap_ext = EW'(new_capacity);
  // narrow counters clip the requested size
  assign cap_sat = (cap_ext > EW'({COUNT_BITS{1'b1}})) ? {COUNT_BITS{1'b1}}
                                                        : cap_ext[COUNT_BITS-1:0];
  assign diff_up = cap_sat - max_cur;
  assign diff_dn = max_cur - cap_sat;
  assign paid    = (debt_cur < diff_up) ? debt_cur : diff_up;
  assign taken   = (free_cur < diff_dn) ? free_cur : diff_dn;

  always_comb begin
    free_nxt = free_cur;
    used_nxt = used_cur;
    debt_nxt = debt_cur;
    max_nxt  = max_cur;
    ok_nxt   = 1'b0;
    unique case (kind) inside
      REQ_RESERVE: begin
        if (free_cur != '0) begin
          free_nxt = free_cur - 1'b1;
          used_nxt = sat_inc(used_cur);
          ok_nxt   = 1'b1;
        end
      end
      REQ_CANCEL: begin
        if (used_cur != '0) begin
          used_nxt = used_cur - 1'b1;
          free_nxt = sat_inc(free_cur);
          ok_nxt   = 1'b1;
        end
      end
      REQ_COMMIT_RM, REQ_ATTEMPT_RM: begin
        if (used_cur != '0) begin
          used_nxt = used_cur - 1'b1;
          // a released slot pays off debt before it becomes free
          if (debt_cur != '0) begin
            debt_nxt = debt_cur - 1'b1;
          end else begin
            free_nxt = sat_inc(free_cur);
          end
          ok_nxt = 1'b1;
        end
      end
      REQ_RESIZE: begin
        if (cap_sat > max_cur) begin
          debt_nxt = debt_cur - paid;
          free_nxt = sat_add(free_cur, diff_up - paid);
        end else if (cap_sat < max_cur) begin
          free_nxt = free_cur - taken;
          debt_nxt = sat_add(debt_cur, diff_dn - taken);
        end
        max_nxt = cap_sat;
        ok_nxt  = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/queue_capacity_credit_tracker.sv
// Capacity accounting for a bounded queue: free credits, occupied entries,
// overflow debt and the current maximum size.
// Input channel: in_valid/in_stall with in_req_type and in_new_capacity
// (resize only). Each request yields exactly one result on the out_ channel:
// out_ok plus the four counters as they stand after that request.
// An accepted request passes two register stages (request register, then
// counter/result register) before it is presented at out_valid.
// Throughput is one request per cycle while out_stall is low; the counter
// update in qcct_update is the only loop, so requests wait only on out_stall.
// When the receiver holds out_stall, the result and counters stay put, the
// request register fills, and then in_stall rises until the result is taken.
// Reset (rst_n low, synchronous) clears all counters to zero and empties
// both stages; a resize is needed before any reserve can succeed.
// Counters are COUNT_BITS wide and saturate; results show their low 16 bits.
module queue_capacity_credit_tracker import qcct_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [REQ_W-1:0] in_req_type,
  input  logic [OUT_W-1:0] in_new_capacity,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_ok,
  output logic [OUT_W-1:0] out_free_credits,
  output logic [OUT_W-1:0] out_occupied,
  output logic [OUT_W-1:0] out_debt,
  output logic [OUT_W-1:0] out_capacity
);

  `include "assert_macros.svh"

  localparam int EW = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

  logic                  in_vld_r;
  logic [REQ_W-1:0]      req_r;
  logic [OUT_W-1:0]      cap_r;
  logic                  out_vld_r;
  logic                  ok_r;
  logic [COUNT_BITS-1:0] free_r, used_r, debt_r, max_r;
  logic [COUNT_BITS-1:0] free_nxt, used_nxt, debt_nxt, max_nxt;
  logic                  ok_nxt;
  logic                  in_take;
  logic                  load;
  logic [EW-1:0]         free_ext, used_ext, debt_ext, max_ext;

  // request moves into the result stage when that stage is empty or draining
  assign load     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !load;
  assign in_take  = in_valid && !in_stall;

  qcct_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .req_type     (req_r),
    .new_capacity (cap_r),
    .free_cur     (free_r),
    .used_cur     (used_r),
    .debt_cur     (debt_r),
    .max_cur      (max_r),
    .free_nxt     (free_nxt),
    .used_nxt     (used_nxt),
    .debt_nxt     (debt_nxt),
    .max_nxt      (max_nxt),
    .ok_nxt       (ok_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= in_req_type;
      cap_r <= in_new_capacity;
    end
  end

  // the counters double as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      free_r    <= '0;
      used_r    <= '0;
      debt_r    <= '0;
      max_r     <= '0;
      ok_r      <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
      free_r    <= free_nxt;
      used_r    <= used_nxt;
      debt_r    <= debt_nxt;
      max_r     <= max_nxt;
      ok_r      <= ok_nxt;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  assign free_ext = EW'(free_r);
  assign used_ext = EW'(used_r);
  assign debt_ext = EW'(debt_r);
  assign max_ext  = EW'(max_r);

  assign out_valid        = out_vld_r;
  assign out_ok           = ok_r;
  assign out_free_credits = free_ext[OUT_W-1:0];
  assign out_occupied     = used_ext[OUT_W-1:0];
  assign out_debt         = debt_ext[OUT_W-1:0];
  assign out_capacity     = max_ext[OUT_W-1:0];

  `ASSERT_NEVER(a_stall_needs_request, in_stall && !in_vld_r, "stall with empty request stage")
  `ASSERT_CLK(a_cap_only_on_resize, (load && req_r != REQ_RESIZE) |=> $stable(max_r), "capacity changed without resize")
  `ASSERT_CLK(a_reserve_takes_credit, (load && req_r == REQ_RESERVE && free_r != '0) |=> (ok_r && (free_r + 1'b1) == $past(free_r)), "reserve did not take a credit")
  `ASSERT_CLK(a_counters_hold, (!load) |=> ($stable(free_r) && $stable(used_r) && $stable(debt_r)), "counters moved without a request")

endmodule
